>>> src/samaw_pkg.sv
package samaw_pkg;

  localparam int unsigned SampleW = 16;
  localparam logic signed [SampleW-1:0] RefXReset = 16'sd32276;
  localparam logic signed [SampleW-1:0] RefYReset = -16'sd5643;
  localparam logic signed [SampleW-1:0] RefZReset = 16'sd371;
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
  localparam logic [16:0] UnitScale = 17'd32767;

  localparam logic [1:0] RegRefX = 2'd0;
  localparam logic [1:0] RegRefY = 2'd1;
  localparam logic [1:0] RegRefZ = 2'd2;

  typedef struct packed {
    logic signed [SampleW-1:0] x;
    logic signed [SampleW-1:0] y;
    logic signed [SampleW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic align;
    logic rd_slot;
    logic upd_sum;
    logic sq_start;
    logic sq_step;
    logic div_start;
    logic div_step;
    logic div_store;
    logic commit_mean;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clearing_done;
    logic window_full;
    logic dot_done;
    logic sq_done;
    logic div_done;
    logic last_axis;
  } dp_sts_t;

  function automatic logic signed [SampleW-1:0] neg_sat(input logic signed [SampleW-1:0] v);
    neg_sat = (v == SampleMin) ? SampleMax : -v;
  endfunction

endpackage

>>> src/samaw_if.sv
interface samaw_in_if import samaw_pkg::*; ();
  logic valid;
  logic ready;
  vec_t accel;
  modport source (output valid, output accel, input ready);
  modport sink (input valid, input accel, output ready);
endinterface

interface samaw_out_if import samaw_pkg::*; ();
  logic valid;
  logic ready;
  vec_t mean;
  logic axis_valid;
  modport source (output valid, output mean, output axis_valid, input ready);
  modport sink (input valid, input mean, input axis_valid, output ready);
endinterface

>>> src/samaw_ctrl.sv
module samaw_ctrl import samaw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    StClear = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StAlign = 10'b0000000100,
    StDot   = 10'b0000001000,
    StRead  = 10'b0000010000,
    StSum   = 10'b0000100000,
    StSqrt  = 10'b0001000000,
    StDivSt = 10'b0010000000,
    StDiv   = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  wire accept = in_valid_i && in_ready_o;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clearing_done) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d = StAlign;
        end
      end
      StAlign: begin
        cmd_o.align = 1'b1;
        state_d = StDot;
      end
      StDot: begin
        if (sts_i.dot_done) state_d = StRead;
      end
      StRead: begin
        cmd_o.rd_slot = 1'b1;
        state_d = StSum;
      end
      StSum: begin
        cmd_o.upd_sum = 1'b1;
        state_d = StSqrt;
      end
      StSqrt: begin
        if (!sts_i.window_full) begin
          state_d = StOut;
        end else begin
          cmd_o.sq_step = 1'b1;
          if (sts_i.sq_done) state_d = StDivSt;
        end
      end
      StDivSt: begin
        cmd_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d = sts_i.last_axis ? StOut : StDivSt;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit_mean = sts_i.window_full;
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StSum) cmd_o.sq_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/samaw_dp.sv
module samaw_dp import samaw_pkg::*; #(
  parameter int unsigned Window = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [SampleW-1:0]    cfg_data_i,
  input  vec_t                  accel_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  output vec_t                  mean_o,
  output logic                  axis_valid_o
);

  localparam int unsigned PtrW = $clog2(Window);
  localparam int unsigned CntW = $clog2(Window + 1);
  localparam int unsigned SumW = SampleW + PtrW;
  localparam int unsigned MagW = 2 * SumW + 2;
  localparam int unsigned RootW = MagW / 2;
  localparam int unsigned SqIter = MagW / 2;
  localparam int unsigned NumW = SumW + 16;
  localparam int unsigned DivIter = 16;
  localparam int unsigned ItW = $clog2(SqIter + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Window - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Window);

  logic signed [SampleW-1:0] ref_x_q, ref_y_q, ref_z_q;
  vec_t smp_q, old_q;
  logic [3*SampleW-1:0] mem_q [Window];
  logic [PtrW-1:0] ptr_q, clr_ptr_q;
  logic [CntW-1:0] fill_q;
  logic signed [SumW-1:0] sx_q, sy_q, sz_q;
  logic signed [2*SampleW+1:0] dot_q;
  logic dot_done_q;
  vec_t held_q, mean_q, new_mean_q;
  logic axis_valid_q;
  logic [RootW-1:0] root_q;
  logic [ItW-1:0] sq_it_q;
  logic [1:0] axis_q;
  logic [NumW-1:0] num_q;
  logic [NumW:0] drem_q;
  logic [4:0] div_it_q;
  logic div_neg_q;

  wire [PtrW-1:0] next_ptr = (ptr_q == LastSlot) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= RefXReset;
      ref_y_q <= RefYReset;
      ref_z_q <= RefZReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRefX: ref_x_q <= cfg_data_i;
        RegRefY: ref_y_q <= cfg_data_i;
        RegRefZ: ref_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dot product, one axis product at a time through one multiplier
  logic signed [SampleW-1:0] mul_a, mul_b;
  logic [1:0] dph_q;
  always_comb begin
    case (dph_q)
      2'd0: begin mul_a = smp_q.x; mul_b = ref_x_q; end
      2'd1: begin mul_a = smp_q.y; mul_b = ref_y_q; end
      default: begin mul_a = smp_q.z; mul_b = ref_z_q; end
    endcase
  end
  wire signed [2*SampleW-1:0] prod = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dph_q <= '0;
      dot_done_q <= 1'b0;
    end else if (cmd_i.load) begin
      dph_q <= '0;
      dot_done_q <= 1'b0;
    end else if (!dot_done_q) begin
      dph_q <= dph_q + 1'b1;
      if (dph_q == 2'd2) dot_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q <= accel_i;
      dot_q <= '0;
    end else if (!dot_done_q) begin
      dot_q <= dot_q + (2*SampleW+2)'(prod);
    end
    if (cmd_i.rd_slot && dot_q[2*SampleW+1]) begin
      smp_q.x <= neg_sat(smp_q.x);
      smp_q.y <= neg_sat(smp_q.y);
      smp_q.z <= neg_sat(smp_q.z);
    end
  end

  // window memory; cleared by a sweep after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) mem_q[clr_ptr_q] <= '0;
    else if (cmd_i.upd_sum) mem_q[ptr_q] <= smp_q;
    if (cmd_i.align) old_q <= mem_q[next_ptr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
      ptr_q <= LastSlot;
      fill_q <= '0;
      sx_q <= '0;
      sy_q <= '0;
      sz_q <= '0;
      held_q <= '0;
    end else begin
      if (cmd_i.clr_step && clr_ptr_q != LastSlot) clr_ptr_q <= clr_ptr_q + 1'b1;
      if (cmd_i.align) ptr_q <= next_ptr;
      if (cmd_i.upd_sum) begin
        sx_q <= sx_q + SumW'(smp_q.x) - SumW'(old_q.x);
        sy_q <= sy_q + SumW'(smp_q.y) - SumW'(old_q.y);
        sz_q <= sz_q + SumW'(smp_q.z) - SumW'(old_q.z);
        if (fill_q != FullCnt) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.commit_mean) held_q <= new_mean_q;
    end
  end

  // magnitude squared then bit-pair square root
  logic [SumW-1:0] ax, ay, az;
  assign ax = sx_q[SumW-1] ? SumW'(-sx_q) : SumW'(sx_q);
  assign ay = sy_q[SumW-1] ? SumW'(-sy_q) : SumW'(sy_q);
  assign az = sz_q[SumW-1] ? SumW'(-sz_q) : SumW'(sz_q);
  logic [1:0] sq_ph_q;
  logic [SumW-1:0] sq_op;
  always_comb begin
    case (sq_ph_q)
      2'd0: sq_op = ax;
      2'd1: sq_op = ay;
      default: sq_op = az;
    endcase
  end
  wire [2*SumW-1:0] sq_full = sq_op * sq_op;
  wire [MagW-1:0] sq_prod = MagW'(sq_full);
  logic sq_acc_q;

  wire [RootW+1:0] trial = {root_q, 2'b01};
  logic [MagW-1:0] rad_q;
  logic [RootW+1:0] part_q;
  wire [RootW+1:0] part_nx = {part_q[RootW-1:0], rad_q[MagW-1 -: 2]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_start) begin
      rad_q <= '0;
      sq_ph_q <= '0;
      sq_acc_q <= 1'b1;
      part_q <= '0;
      root_q <= '0;
      sq_it_q <= '0;
    end else if (cmd_i.sq_step) begin
      if (sq_acc_q) begin
        rad_q <= rad_q + sq_prod;
        sq_ph_q <= sq_ph_q + 1'b1;
        if (sq_ph_q == 2'd2) sq_acc_q <= 1'b0;
      end else begin
        rad_q <= {rad_q[MagW-3:0], 2'b00};
        sq_it_q <= sq_it_q + 1'b1;
        if (part_nx >= trial) begin
          part_q <= part_nx - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          part_q <= part_nx;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  logic signed [SumW-1:0] cur_s;
  always_comb begin
    case (axis_q)
      2'd0: cur_s = sx_q;
      2'd1: cur_s = sy_q;
      default: cur_s = sz_q;
    endcase
  end
  logic [SumW-1:0] cur_mag;
  assign cur_mag = cur_s[SumW-1] ? SumW'(-cur_s) : SumW'(cur_s);
  wire [SumW+16:0] num_full = cur_mag * UnitScale;
  wire [NumW-1:0] num_mult = NumW'(num_full);

  logic [NumW:0] dsh;
  assign dsh = {drem_q[NumW-1:0], num_q[NumW-1]};
  wire [NumW:0] dsor = (NumW+1)'(root_q);
  wire [15:0] qmag = num_q[15:0];
  wire [SampleW-1:0] qsat = (qmag > 16'd32767) ? 16'd32767 : qmag;
  wire signed [SampleW-1:0] qs = div_neg_q ? -$signed(qsat) : $signed(qsat);
  wire div_fin = (div_it_q == 5'(DivIter));

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_start) axis_q <= '0;
    if (cmd_i.div_start) begin
      num_q <= num_mult << (NumW - DivIter);
      drem_q <= (NumW+1)'(num_mult >> DivIter);
      div_it_q <= '0;
      div_neg_q <= cur_s[SumW-1];
    end else if (cmd_i.div_step && !div_fin) begin
      div_it_q <= div_it_q + 1'b1;
      if (dsh >= dsor) begin
        drem_q <= dsh - dsor;
        num_q <= {num_q[NumW-2:0], 1'b1};
      end else begin
        drem_q <= dsh;
        num_q <= {num_q[NumW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_store) begin
      axis_q <= axis_q + 1'b1;
      case (axis_q)
        2'd0: new_mean_q.x <= (root_q == '0) ? '0 : qs;
        2'd1: new_mean_q.y <= (root_q == '0) ? '0 : qs;
        default: new_mean_q.z <= (root_q == '0) ? '0 : qs;
      endcase
    end
    if (cmd_i.out_load) begin
      mean_q <= sts_o.window_full ? new_mean_q : held_q;
      axis_valid_q <= sts_o.window_full;
    end
  end

  assign sts_o.clearing_done = (clr_ptr_q == LastSlot);
  assign sts_o.window_full   = (fill_q == FullCnt);
  assign sts_o.dot_done      = dot_done_q;
  assign sts_o.sq_done       = !sq_acc_q && (sq_it_q == ItW'(SqIter - 1)) && cmd_i.sq_step;
  assign sts_o.div_done      = div_fin;
  assign sts_o.last_axis     = (axis_q == 2'd2);
  assign mean_o       = mean_q;
  assign axis_valid_o = axis_valid_q;

endmodule

>>> src/sign_aligned_mean_axis_window_top.sv
// path: an input beat goes through align, dot product, sign fix and window sum, then the root and one divide per axis
// before the window is full the root and divides are skipped and the held mean is sent; one beat in flight at a time
// a result beat may wait in the output register while the next beat is taken
// reset: async active low; after reset a sweep clears every slot of the window memory
// input ready stays low during the sweep
module sign_aligned_mean_axis_window_top import samaw_pkg::*; #(
  parameter int unsigned WINDOW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [SampleW-1:0] cfg_data_i,
  samaw_in_if.sink           in_if,
  samaw_out_if.source        out_if
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  samaw_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  samaw_dp #(.Window(WINDOW)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .accel_i     (in_if.accel),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mean_o      (out_if.mean),
    .axis_valid_o(out_if.axis_valid)
  );

endmodule

>>> src/samaw_checker.sv
module samaw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic axis_valid
);

  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready, out_valid})) else $error("handshake unknown");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_axis_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(axis_valid)) else $error("flag changed in stall");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken while busy");

endmodule

bind sign_aligned_mean_axis_window_top samaw_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .axis_valid(out_if.axis_valid)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import samaw_pkg::*;

  localparam int unsigned Win = 32;
  localparam int unsigned LimitCycles = 2000000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               axis_valid;
  } mean_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegRefX;
  logic [15:0] cfg_data_i = '0;

  samaw_in_if in_ch ();
  samaw_out_if out_ch ();

  sign_aligned_mean_axis_window_top #(.WINDOW(Win)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] axis_ref [3];
  logic signed [15:0] ring_x [Win], ring_y [Win], ring_z [Win];
  logic signed [31:0] acc_x, acc_y, acc_z;
  int unsigned slot_ptr, filled;
  logic signed [15:0] kept [3];

  vec_t pending_samples [$];
  mean_beat_t expected_means [$];
  int unsigned send_idle_pct = 10, recv_idle_pct = 49;
  int unsigned mismatches = 0;
  bit in_fire = 0;
  longint unsigned cycle_count = 0;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] unit_comp(longint s, longint unsigned r);
    longint unsigned mag, q;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = (mag * 32767) / r;
    if (q > 32767) q = 32767;
    return (s < 0) ? -16'(q) : 16'(q);
  endfunction

  task automatic predict_mean(input vec_t a);
    longint dot, sx, sy, sz;
    longint unsigned r;
    logic signed [15:0] vx, vy, vz;
    mean_beat_t m;
    vx = a.x; vy = a.y; vz = a.z;
    dot = longint'(vx) * axis_ref[0] + longint'(vy) * axis_ref[1]
        + longint'(vz) * axis_ref[2];
    if (dot < 0) begin
      vx = neg_sat(vx); vy = neg_sat(vy); vz = neg_sat(vz);
    end
    slot_ptr = (slot_ptr + 1 >= Win) ? 0 : slot_ptr + 1;
    acc_x = acc_x + vx - ring_x[slot_ptr];
    acc_y = acc_y + vy - ring_y[slot_ptr];
    acc_z = acc_z + vz - ring_z[slot_ptr];
    ring_x[slot_ptr] = vx; ring_y[slot_ptr] = vy; ring_z[slot_ptr] = vz;
    if (filled < Win) filled++;
    m.axis_valid = 1'b0;
    if (filled >= Win) begin
      sx = acc_x; sy = acc_y; sz = acc_z;
      r = root_floor(longint'(sx * sx + sy * sy + sz * sz));
      if (r == 0) begin
        kept[0] = 0; kept[1] = 0; kept[2] = 0;
      end else begin
        kept[0] = unit_comp(sx, r);
        kept[1] = unit_comp(sy, r);
        kept[2] = unit_comp(sz, r);
      end
      m.axis_valid = 1'b1;
    end
    m.x = kept[0]; m.y = kept[1]; m.z = kept[2];
    expected_means.push_back(m);
  endtask

  // driver
  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_fire) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.accel <= pending_samples.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accepted input feeds the predictor; output beats are checked
  always @(posedge clk_i) begin
    mean_beat_t e;
    if (rst_ni) begin
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) predict_mean(in_ch.accel);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %h", out_ch.mean);
        end else begin
          e = expected_means.pop_front();
          if (out_ch.mean.x !== e.x || out_ch.mean.y !== e.y || out_ch.mean.z !== e.z
              || out_ch.axis_valid !== e.axis_valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0d %0d %0d v%0b got %0d %0d %0d v%0b",
                       e.x, e.y, e.z, e.axis_valid, out_ch.mean.x, out_ch.mean.y,
                       out_ch.mean.z, out_ch.axis_valid);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_ref(input logic [1:0] idx, input logic signed [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    axis_ref[idx] = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending_samples.size() > 0 || in_ch.valid || expected_means.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(7))
      0: return SampleMin;
      1: return SampleMax;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic signed [15:0] x, y, z);
    vec_t v;
    v.x = x; v.y = y; v.z = z;
    pending_samples.push_back(v);
  endtask

  initial begin
    vec_t base;
    axis_ref[0] = RefXReset; axis_ref[1] = RefYReset; axis_ref[2] = RefZReset;
    for (int i = 0; i < Win; i++) begin
      ring_x[i] = 0; ring_y[i] = 0; ring_z[i] = 0;
    end
    acc_x = 0; acc_y = 0; acc_z = 0;
    slot_ptr = Win - 1; filled = 0;
    kept[0] = 0; kept[1] = 0; kept[2] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, zero dot, saturating negation
    push_sample(SampleMin, SampleMin, SampleMin);
    push_sample(SampleMax, SampleMax, SampleMax);
    push_sample(0, 0, 0);
    push_sample(SampleMin, 0, 0);
    push_sample(0, SampleMax, 0);
    push_sample(0, 0, SampleMin);
    push_sample(5643, 32276, 0);
    for (int i = 0; i < 18; i++) push_sample(0, 0, 0);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin write_ref(RegRefX, SampleMax); write_ref(RegRefY, 0); write_ref(RegRefZ, 0); end
        1: begin write_ref(RegRefX, SampleMin); write_ref(RegRefY, SampleMin);
                 write_ref(RegRefZ, SampleMin); end
        2: begin write_ref(RegRefX, 0); write_ref(RegRefY, 0); write_ref(RegRefZ, 0); end
        3: begin write_ref(RegRefX, 0); write_ref(RegRefY, SampleMax);
                 write_ref(RegRefZ, SampleMax); end
        default: begin write_ref(RegRefX, 16'($urandom)); write_ref(RegRefY, 16'($urandom));
                       write_ref(RegRefZ, 16'($urandom)); end
      endcase
      if (phase == 3) begin send_idle_pct = 49; recv_idle_pct = 10; end
      if (phase == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      base.x = 16'($urandom); base.y = 16'($urandom); base.z = 16'($urandom);
      for (int i = 0; i < 114; i++) begin
        if ($urandom_range(3) == 0)
          push_sample(rand_comp(), rand_comp(), rand_comp());
        else
          push_sample(base.x + 16'($urandom_range(2000)) - 16'd1000,
                      base.y + 16'($urandom_range(2000)) - 16'd1000,
                      base.z + 16'($urandom_range(2000)) - 16'd1000);
      end
      drain();
    end

    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/samaw_pkg.sv
src/samaw_if.sv
src/samaw_ctrl.sv
src/samaw_dp.sv
src/sign_aligned_mean_axis_window_top.sv
src/samaw_checker.sv
tb/sv/testbench.sv
